/* hdl/suks_pkg.sv */
// Shared types and constants for the sorted unique key set.
package suks_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // flipping the sign bit makes unsigned order match signed order
    localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef enum logic [1:0] {
        RD_IDX     = 2'd0,
        RD_PTR_DN  = 2'd1,
        RD_PTR_UP  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic                load;
        logic                mem_rd;
        rd_sel_t             rd_sel;
        logic                idx_inc;
        logic                ptr_load_up;
        logic                ptr_load_dn;
        logic                shift_wr_up;
        logic                shift_wr_dn;
        logic                key_wr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_use_pos;
        logic                res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             scan_end;
        logic             key_lt;
        logic             key_eq;
        logic             full;
        logic             up_done;
        logic             dn_done;
    } dp_stat_t;

endpackage

/* hdl/suks_if.sv */
// Request and response channel interfaces of the sorted unique key set.
interface suks_req_if;
    logic                               valid;
    logic                               ready;
    logic [suks_pkg::CMD_W-1:0]         command;
    logic signed [suks_pkg::KEY_W-1:0]  key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface suks_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [suks_pkg::STATUS_W-1:0]      status;
    logic [suks_pkg::POS_W-1:0]         position;
    logic [suks_pkg::COUNT_W-1:0]       entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

/* hdl/suks_ctrl.sv */
// Sequencing state machine: scan, shift and response hand-off.
module suks_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  suks_pkg::dp_stat_t stat,
    output suks_pkg::dp_cmd_t  cmd
);
    import suks_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CMP = 9'b000000100,
        S_UP_STEP  = 9'b000001000,
        S_UP_MOVE  = 9'b000010000,
        S_DN_STEP  = 9'b000100000,
        S_DN_MOVE  = 9'b001000000,
        S_RESP     = 9'b010000000,
        S_SPARE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   scan_done;
    logic   hit;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        state_next = state_reg;
        scan_done  = 1'b0;
        hit        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    scan_done = 1'b1;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.key_lt)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else
                begin
                    scan_done = 1'b1;
                    hit       = stat.key_eq;
                end
            end
            S_UP_STEP:
            begin
                if (stat.up_done)
                begin
                    cmd.key_wr  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_PTR_DN;
                    state_next = S_UP_MOVE;
                end
            end
            S_UP_MOVE:
            begin
                cmd.shift_wr_up = 1'b1;
                state_next      = S_UP_STEP;
            end
            S_DN_STEP:
            begin
                if (stat.dn_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_PTR_UP;
                    state_next = S_DN_MOVE;
                end
            end
            S_DN_MOVE:
            begin
                cmd.shift_wr_dn = 1'b1;
                state_next      = S_DN_STEP;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // lower bound found: pick the outcome and the follow-up work
        if (scan_done)
        begin
            cmd.res_set     = 1'b1;
            cmd.res_status  = ST_MISS;
            cmd.res_use_pos = 1'b0;
            state_next      = S_RESP;
            unique case (stat.command)
                CMD_INSERT:
                begin
                    if (hit)
                    begin
                        cmd.res_use_pos = 1'b1;
                    end
                    else if (stat.full)
                    begin
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.res_status  = ST_OK;
                        cmd.res_use_pos = 1'b1;
                        cmd.ptr_load_up = 1'b1;
                        state_next      = S_UP_STEP;
                    end
                end
                CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        cmd.res_status  = ST_OK;
                        cmd.res_use_pos = 1'b1;
                        cmd.ptr_load_dn = 1'b1;
                        state_next      = S_DN_STEP;
                    end
                end
                CMD_SEARCH:
                begin
                    if (hit)
                    begin
                        cmd.res_status  = ST_OK;
                        cmd.res_use_pos = 1'b1;
                    end
                end
                default:
                begin
                    cmd.res_status = ST_MISS;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    // a new result never overwrites a beat still waiting on the response side
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> slot_free)
        else $error("result loaded over a pending beat");

    // a shift is only started by a finished scan
    a_shift_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ptr_load_up || cmd.ptr_load_dn) |->
            ($past(state_reg) == S_SCAN_RD || $past(state_reg) == S_SCAN_CMP
             || state_reg == S_SCAN_RD || state_reg == S_SCAN_CMP))
        else $error("shift started outside the scan");
`endif

endmodule

/* hdl/suks_dpath.sv */
// Key memory, scan and shift pointers, entry count and result registers.
module suks_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [suks_pkg::CMD_W-1:0]            command,
    input  logic signed [suks_pkg::KEY_W-1:0]     key,
    input  suks_pkg::dp_cmd_t                     cmd,
    output suks_pkg::dp_stat_t                    stat,
    output logic [suks_pkg::STATUS_W-1:0]         status,
    output logic [suks_pkg::POS_W-1:0]            position,
    output logic [suks_pkg::COUNT_W-1:0]          entry_count
);
    import suks_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0]    mem [CAPACITY];
    logic [KEY_W-1:0]    rd_data_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_m1, ptr_p1;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [POS_W-1:0]    pend_pos_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [POS_W-1:0]    position_reg;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [KEY_W-1:0]    wr_data;

    assign ptr_m1 = ptr_reg - 1'b1;
    assign ptr_p1 = ptr_reg + 1'b1;

    assign stat.command  = cmd_reg;
    assign stat.scan_end = (idx_reg == count_reg);
    assign stat.key_lt   = (rd_data_reg < key_reg);
    assign stat.key_eq   = (rd_data_reg == key_reg);
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.up_done  = (ptr_reg == idx_reg);
    assign stat.dn_done  = (ptr_p1 >= count_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX:    rd_addr = idx_reg[AW-1:0];
            RD_PTR_DN: rd_addr = ptr_m1[AW-1:0];
            RD_PTR_UP: rd_addr = ptr_p1[AW-1:0];
            default:   rd_addr = idx_reg[AW-1:0];
        endcase
    end

    assign mem_we  = cmd.key_wr || cmd.shift_wr_up || cmd.shift_wr_dn;
    assign wr_addr = cmd.key_wr ? idx_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = cmd.key_wr ? key_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        priority if (cmd.ptr_load_up)
            ptr_next = count_reg;
        else if (cmd.ptr_load_dn)
            ptr_next = idx_reg;
        else if (cmd.shift_wr_up)
            ptr_next = ptr_m1;
        else if (cmd.shift_wr_dn)
            ptr_next = ptr_p1;
        else
            ptr_next = ptr_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            key_reg <= key ^ SIGN_FLIP;
        end
        if (cmd.res_set)
        begin
            pend_status_reg <= cmd.res_status;
            pend_pos_reg    <= cmd.res_use_pos ? POS_W'(idx_reg) : '0;
        end
        if (cmd.res_load)
        begin
            status_reg      <= pend_status_reg;
            position_reg    <= pend_pos_reg;
            entry_count_reg <= COUNT_W'(count_reg);
        end
    end

    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTH
    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CW'(CAPACITY)))
        else $error("insert into a full store");

    a_inc_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count did not step on insert");

    a_up_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr_up |-> (ptr_reg > idx_reg))
        else $error("upward shift passed the insertion point");

    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_rd && mem_we))
        else $error("memory read and write in one cycle");
`endif

endmodule

/* hdl/sorted_unique_key_set_core.sv */
// Sorted unique key set: top level joining controller and datapath.
//
// Usage: req carries one beat per operation (command, signed key); rsp returns
// exactly one beat per request (status, position, entry_count), in order.
// Keys are held in ascending order in a single-port memory of CAPACITY words.
// Insert shifts larger keys up, remove closes the gap, search only scans.
// The scan reads one entry at a time up to the first key not below the
// request key; a shift then moves the entries one at a time. The memory takes
// one access per cycle, and its read data is registered.
// One operation is in flight at a time; req.ready is high only when idle, so
// a new request is taken only after the previous result has been loaded.
// Results sit in an output register: while rsp.ready is low the beat holds,
// and a finished operation waits for the slot before the next request is taken.
// Reset (rst_n low, asynchronous) empties the set and drops any pending beat;
// memory contents are not cleared, only the entry count.
module sorted_unique_key_set_core #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    suks_req_if.sink    req,
    suks_rsp_if.source  rsp
);
    import suks_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    suks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    suks_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (req.command),
        .key         (req.key),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .status      (rsp.status),
        .position    (rsp.position),
        .entry_count (rsp.entry_count)
    );

endmodule
